// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition must never hold.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ----- rtl/cms_pkg.sv -----
// Shared types and constants of the cosine match unit.
package cms_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int DOT_W    = 43;
    localparam int NORM_W   = 42;
    localparam int DIST_W   = 16;
    localparam int STREAK_W = 8;

    localparam logic [1:0] OP_PAIR   = 2'd0;
    localparam logic [1:0] OP_NOFACE = 2'd1;
    localparam logic [1:0] OP_FAIL   = 2'd2;

    localparam logic [1:0] KIND_MATCH   = 2'd0;
    localparam logic [1:0] KIND_NOFACE  = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;
    localparam logic [1:0] KIND_OVERRUN = 2'd3;

    localparam logic [DIST_W-1:0]   ONE_Q14      = 16'd16384;
    localparam logic [DIST_W-1:0]   THR_RESET    = 16'd6554;
    localparam logic [STREAK_W-1:0] REQ_RESET    = 8'd5;
    localparam logic [STREAK_W-1:0] STREAK_MAX   = 8'd255;

    localparam logic [0:0] CFG_THRESHOLD = 1'b0;
    localparam logic [0:0] CFG_REQUIRED  = 1'b1;

    // One finished vector or frame event handed to the back end.
    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DOT_W-1:0]  dot;
        logic [NORM_W-1:0]        probe_norm;
        logic [NORM_W-1:0]        ref_norm;
    } job_t;

endpackage

// ----- rtl/cms_front.sv -----
// Front end: accepts element words, accumulates dot product and norms, issues jobs.
module cms_front import cms_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // probe_elem[15:0], ref_elem[31:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        s_tlast,
    input  logic        q_full,
    output logic        push,
    output job_t        push_job
);

    logic signed [DOT_W-1:0]  dot_reg, dot_next, dot_sum;
    logic [NORM_W-1:0]        pn_reg, pn_next, pn_sum;
    logic [NORM_W-1:0]        rn_reg, rn_next, rn_sum;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovr_reg, ovr_next;
    logic signed [15:0]       a, b;
    logic signed [31:0]       p_ab, p_aa, p_bb;
    logic                     accept, in_range;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign a        = signed'(s_tdata[15:0]);
    assign b        = signed'(s_tdata[31:16]);
    assign p_ab     = a * b;
    assign p_aa     = a * a;
    assign p_bb     = b * b;
    assign in_range = cnt_reg < CNT_W'(MAX_LEN);
    assign dot_sum  = in_range ? dot_reg + DOT_W'(p_ab) : dot_reg;
    assign pn_sum   = in_range ? pn_reg + NORM_W'(unsigned'(p_aa)) : pn_reg;
    assign rn_sum   = in_range ? rn_reg + NORM_W'(unsigned'(p_bb)) : rn_reg;

    // Accumulate pairs; close the vector on last or on a frame event.
    always_comb begin
        dot_next = dot_reg;
        pn_next  = pn_reg;
        rn_next  = rn_reg;
        cnt_next = cnt_reg;
        ovr_next = ovr_reg;
        push     = 1'b0;
        push_job = '{kind: KIND_MATCH, dot: dot_sum, probe_norm: pn_sum, ref_norm: rn_sum};
        if (accept) begin
            case (s_tuser)
                OP_PAIR: begin
                    if (in_range) begin
                        dot_next = dot_sum;
                        pn_next  = pn_sum;
                        rn_next  = rn_sum;
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        ovr_next = 1'b1;
                    end
                    if (s_tlast) begin
                        push = 1'b1;
                        if (ovr_reg || !in_range) begin
                            push_job.kind = KIND_OVERRUN;
                        end
                        dot_next = '0;
                        pn_next  = '0;
                        rn_next  = '0;
                        cnt_next = '0;
                        ovr_next = 1'b0;
                    end
                end
                OP_NOFACE, OP_FAIL: begin
                    push          = 1'b1;
                    push_job.kind = (s_tuser == OP_NOFACE) ? KIND_NOFACE : KIND_FAIL;
                    dot_next      = '0;
                    pn_next       = '0;
                    rn_next       = '0;
                    cnt_next      = '0;
                    ovr_next      = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            pn_reg  <= '0;
            rn_reg  <= '0;
            cnt_reg <= '0;
            ovr_reg <= 1'b0;
        end else begin
            dot_reg <= dot_next;
            pn_reg  <= pn_next;
            rn_reg  <= rn_next;
            cnt_reg <= cnt_next;
            ovr_reg <= ovr_next;
        end
    end

endmodule

// ----- rtl/cms_fifo.sv -----
// Two-entry job queue between the front and back ends.
module cms_fifo import cms_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign pop_job = mem_reg[rd_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/cms_back.sv -----
// Back end: roots, product, long division, streak update and result register.
module cms_back import cms_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  job_t                job,
    output logic                pop,
    input  logic [DIST_W-1:0]   threshold,
    input  logic [STREAK_W-1:0] required,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]              st_reg, st_next;
    job_t                    job_reg, job_next;
    logic                    sel_reg, sel_next;
    logic [63:0]             x_reg, x_next, root_reg, root_next, bit_reg, bit_next;
    logic [4:0]              k_reg, k_next, ka_reg, ka_next, kb_reg, kb_next;
    logic [30:0]             ra_reg, ra_next, rb_reg, rb_next;
    logic [61:0]             d_reg, d_next;
    logic [63:0]             r_reg, r_next;
    logic [40:0]             q_reg, q_next;
    logic [6:0]              step_reg, step_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic [DIST_W-1:0]       ld_reg, ld_next;
    logic                    lv_reg, lv_next;
    logic [STREAK_W-1:0]     stk_reg, stk_next;
    logic                    mv_reg, mv_next;
    logic [31:0]             md_reg, md_next;

    logic [63:0]             trial, r_sh, r_it;
    logic [40:0]             q_sh, q_it, q_rnd;
    logic [DOT_W-1:0]        dot_abs;
    logic [6:0]              steps;
    logic [DIST_W-1:0]       mag;
    logic                    out_free, neg;

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign out_free = !mv_reg || m_tready;
    assign neg      = job_reg.dot[DOT_W-1];
    assign dot_abs  = neg ? -job_reg.dot : job_reg.dot;
    assign trial    = root_reg + bit_reg;
    assign steps    = 7'd15 + 7'(ka_reg) + 7'(kb_reg);
    assign pop      = (st_reg == ST_IDLE) && job_valid;

    // One restoring long-division step.
    always_comb begin
        r_sh = {r_reg[62:0], 1'b0};
        q_sh = {q_reg[39:0], 1'b0};
        r_it = r_sh;
        q_it = q_sh;
        if (r_sh >= {2'b00, d_reg}) begin
            r_it = r_sh - {2'b00, d_reg};
            q_it = q_sh | 41'd1;
        end
        q_rnd = (q_it + 41'd1) >> 1;
        mag   = (q_rnd > 41'(ONE_Q14)) ? ONE_Q14 : q_rnd[DIST_W-1:0];
    end

    // Sequencer over normalize, root, multiply, divide and retire.
    always_comb begin
        st_next   = st_reg;
        job_next  = job_reg;
        sel_next  = sel_reg;
        x_next    = x_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        k_next    = k_reg;
        ka_next   = ka_reg;
        kb_next   = kb_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        step_next = step_reg;
        dist_next = dist_reg;
        ld_next   = ld_reg;
        lv_next   = lv_reg;
        stk_next  = stk_reg;
        mv_next   = mv_reg && !m_tready;
        md_next   = md_reg;
        case (st_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_next = job;
                    sel_next = 1'b0;
                    x_next   = 64'(job.probe_norm);
                    k_next   = '0;
                    if (job.kind == KIND_MATCH &&
                        (job.probe_norm == '0 || job.ref_norm == '0)) begin
                        dist_next = ONE_Q14;
                        st_next   = ST_DONE;
                    end else if (job.kind == KIND_MATCH) begin
                        st_next = ST_NORM;
                    end else begin
                        st_next = ST_DONE;
                    end
                end
            end
            ST_NORM: begin
                // Even left shift until the norm reaches 2^60.
                if (x_reg[63:60] == 4'd0) begin
                    x_next = {x_reg[61:0], 2'b00};
                    k_next = k_reg + 1'b1;
                end else begin
                    root_next = '0;
                    bit_next  = 64'd1 << 62;
                    st_next   = ST_ROOT;
                end
            end
            ST_ROOT: begin
                // Digit-by-digit square root, two radicand bits a cycle.
                if (x_reg >= trial) begin
                    x_next    = x_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    if (!sel_reg) begin
                        ra_next  = root_next[30:0];
                        ka_next  = k_reg;
                        sel_next = 1'b1;
                        x_next   = 64'(job_reg.ref_norm);
                        k_next   = '0;
                        st_next  = ST_NORM;
                    end else begin
                        rb_next = root_next[30:0];
                        kb_next = k_reg;
                        st_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                d_next    = ra_reg * rb_reg;
                r_next    = 64'(dot_abs);
                q_next    = '0;
                step_next = '0;
                st_next   = ST_DIV;
            end
            ST_DIV: begin
                r_next    = r_it;
                q_next    = q_it;
                step_next = step_reg + 1'b1;
                if (step_reg + 7'd1 == steps || q_it[40]) begin
                    dist_next = neg ? ONE_Q14 + mag : ONE_Q14 - mag;
                    st_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                // Retire into the result register once it is free.
                if (out_free) begin
                    case (job_reg.kind)
                        KIND_MATCH: begin
                            ld_next = dist_reg;
                            lv_next = 1'b1;
                            if (dist_reg <= threshold) begin
                                stk_next = (stk_reg == STREAK_MAX) ? stk_reg
                                                                   : stk_reg + 1'b1;
                            end else begin
                                stk_next = '0;
                            end
                        end
                        KIND_NOFACE: begin
                            ld_next  = '0;
                            lv_next  = 1'b0;
                            stk_next = '0;
                        end
                        default: begin
                            stk_next = '0;
                        end
                    endcase
                    mv_next = 1'b1;
                    md_next = {5'd0, job_reg.kind == KIND_OVERRUN,
                               stk_next >= required, stk_next, lv_next, ld_next};
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            ld_reg  <= '0;
            lv_reg  <= 1'b0;
            stk_reg <= '0;
            mv_reg  <= 1'b0;
        end else begin
            st_reg  <= st_next;
            ld_reg  <= ld_next;
            lv_reg  <= lv_next;
            stk_reg <= stk_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        sel_reg  <= sel_next;
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        k_reg    <= k_next;
        ka_reg   <= ka_next;
        kb_reg   <= kb_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        dist_reg <= dist_next;
        md_reg   <= md_next;
    end

endmodule

// ----- rtl/cosine_match_with_streak_unit.sv -----
// Element words are taken one a cycle while the job queue is not full; each accepted pair
// within the length limit is multiply-accumulated into the dot product and both norms.
// A vector result passes through the bit-serial root unit (normalize, then root, for each
// norm), a multiply and the long divider; a frame event or a zero norm skips them.
// A two-entry job queue lets the next vector accumulate while the back end works.
// aresetn is synchronous, active low: clears accumulators, streak, distance, loads defaults.
`include "assert_macros.svh"

module cosine_match_with_streak_unit import cms_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // probe_elem[15:0], ref_elem[31:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // distance[15:0], distance_valid[16], streak[24:17],
                                   // unlocked[25], length_error[26], zero[31:27]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [DIST_W-1:0]   thr_reg;
    logic [STREAK_W-1:0] req_reg;
    logic                push, pop, q_full, q_empty;
    job_t                push_job, pop_job;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            req_reg <= REQ_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_THRESHOLD: thr_reg <= cfg_wdata;
                CFG_REQUIRED:  req_reg <= cfg_wdata[STREAK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    cms_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    cms_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!q_empty),
        .job       (pop_job),
        .pop       (pop),
        .threshold (thr_reg),
        .required  (req_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && q_full)
    `ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && q_empty)
    `ASSERT_IMPLIES(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tdata[16], m_tdata[15:0] == 16'd0)
    `ASSERT_IMPLIES(a_lenerr_clears, aclk, aresetn, m_tvalid && m_tdata[26], m_tdata[24:17] == 8'd0)

endmodule
